@@ rtl/rms_level_meter_assert.svh @@
// assertion macros used by rms_level_meter
`ifndef RMS_LEVEL_METER_ASSERT_SVH
`define RMS_LEVEL_METER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RLM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("rlm assertion failed");

// next-cycle implication, checked outside reset
`define RLM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("rlm assertion failed");

`endif

@@ rtl/rlm_pkg.sv @@
package rlm_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int LEVEL_W       = 16;
  localparam int MAX_COUNT_DEF = 4096;

  // a square is at most 2^30, so it fits 31 bits
  localparam int SQ_W     = 31;
  // the mean is never above the largest square
  localparam int MEAN_W   = 31;
  // radicand padded to an even width for the two-bit root steps
  localparam int RAD_W    = 32;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int ROOT_REM_W = ROOT_W + 1;
  localparam int STEP_W   = $clog2(MEAN_W);

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

endpackage

@@ rtl/rlm_if.sv @@
interface rlm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [rlm_pkg::SAMPLE_W-1:0] sample_value;

  modport source (output valid, output command, output sample_value, input ready);
  modport sink   (input valid, input command, input sample_value, output ready);
endinterface

interface rlm_out_if;
  logic                         valid;
  logic                         ready;
  logic [rlm_pkg::LEVEL_W-1:0]  level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

@@ rtl/rlm_subcmp.sv @@
module rlm_subcmp #(
  parameter int W = 19
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] diff_o,
  output logic         ge_o
);

  logic [W:0] full;

  // borrow out of the top bit means a < b
  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[W-1:0];
  assign ge_o   = ~full[W];

endmodule

@@ rtl/rms_level_meter.sv @@
// rms level meter. a sample transfer (command 0) squares the signed 16-bit
// sample into sq_q and adds it to the running sum in ST_ACC, the input not ready
// there. once MAX_COUNT samples are held, further samples are taken and dropped.
// a tick transfer (command 1) with samples pending produces one level,
// floor(sqrt(floor(sum / count))), then clears the sum and the count; a tick
// with nothing pending is taken and produces nothing. a tick loads the dividend,
// runs 31 restoring divide steps (one quotient bit each), then 16 square root
// steps (one root bit each) on the same shared compare-subtract unit, and last
// hands the level to the output register. the output register
// holds the level until it is taken, so samples keep flowing meanwhile; a tick
// that finishes while the previous level is still unread waits in its last
// state. there is no clearing pass after reset.
module rms_level_meter #(
  parameter int MAX_COUNT = rlm_pkg::MAX_COUNT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rlm_in_if.sink   sample_i,
  rlm_out_if.source level_o
);

  import rlm_pkg::*;

  // counter wide enough to hold MAX_COUNT itself
  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  localparam int SUM_W = CNT_W + SQ_W - 1;
  // remainder register serves both the divide and the root
  localparam int REM_W = (CNT_W > ROOT_REM_W) ? CNT_W : ROOT_REM_W;
  // shared unit width covers a remainder shifted by up to two bits
  localparam int UW    = REM_W + 2;
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_COUNT);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(MEAN_W - 1);
  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_W - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ACC  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_SQRT = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // accumulator state
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pending_q, pending_d;
  logic [SQ_W-1:0]   sq_q, sq_d;

  // iteration state
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [RAD_W-1:0]  sh_q, sh_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [STEP_W-1:0] step_q, step_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0] level_q, level_d;

  logic                in_xfer;
  logic                out_free;
  logic [SAMPLE_W-1:0] mag;
  logic [2*SAMPLE_W-1:0] prod;
  logic [UW-1:0]       unit_a, unit_b, unit_diff;
  logic                unit_ge;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_xfer        = sample_i.valid & sample_i.ready;
  assign out_free       = ~out_valid_q | level_o.ready;

  assign level_o.valid  = out_valid_q;
  assign level_o.level  = level_q;

  // magnitude of a two's complement sample; the most negative one maps to 0x8000
  assign mag  = sample_i.sample_value[SAMPLE_W-1] ?
                SAMPLE_W'(-sample_i.sample_value) : SAMPLE_W'(sample_i.sample_value);
  assign prod = {{SAMPLE_W{1'b0}}, mag} * {{SAMPLE_W{1'b0}}, mag};

  // operand select for the shared compare-subtract unit
  always_comb begin
    if (state_q == ST_SQRT) begin
      // bring down two radicand bits, trial subtract 4*root + 1
      unit_a = UW'({rem_q[ROOT_REM_W-1:0], sh_q[RAD_W-1 -: 2]});
      unit_b = UW'({root_q, 2'b01});
    end else begin
      // bring down one dividend bit, trial subtract the count
      unit_a = UW'({rem_q[CNT_W-1:0], sh_q[MEAN_W-1]});
      unit_b = UW'(cnt_q);
    end
  end

  rlm_subcmp #(
    .W (UW)
  ) u_subcmp (
    .a_i    (unit_a),
    .b_i    (unit_b),
    .diff_o (unit_diff),
    .ge_o   (unit_ge)
  );

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    pending_d   = pending_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    sh_d        = sh_q;
    root_d      = root_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    level_d     = level_q;

    if (level_o.valid && level_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (sample_i.command == CMD_SAMPLE) begin
            // a full count drops the sample
            if (cnt_q < CNT_MAX) begin
              sq_d    = prod[SQ_W-1:0];
              state_d = ST_ACC;
            end
          end else if (pending_q) begin
            // high sum bits are below the count, so 31 quotient bits suffice
            rem_d   = REM_W'(sum_q >> MEAN_W);
            sh_d    = {1'b0, sum_q[MEAN_W-1:0]};
            step_d  = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_ACC: begin
        sum_d     = sum_q + SUM_W'(sq_q);
        cnt_d     = cnt_q + CNT_W'(1);
        pending_d = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_DIV: begin
        rem_d  = unit_ge ? REM_W'(unit_diff) : REM_W'(unit_a);
        sh_d   = {1'b0, sh_q[MEAN_W-2:0], unit_ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == DIV_LAST) begin
          // quotient is now the radicand; root starts from scratch
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        rem_d  = unit_ge ? REM_W'(unit_diff) : REM_W'(unit_a);
        sh_d   = {sh_q[RAD_W-3:0], 2'b00};
        root_d = {root_q[ROOT_W-2:0], unit_ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == ROOT_LAST) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait here while an earlier level is still unread
        if (out_free) begin
          level_d     = root_q;
          out_valid_d = 1'b1;
          sum_d       = '0;
          cnt_d       = '0;
          pending_d   = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      pending_q   <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      pending_q   <= pending_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    sq_q    <= sq_d;
    rem_q   <= rem_d;
    sh_q    <= sh_d;
    root_q  <= root_d;
    level_q <= level_d;
  end

`include "rms_level_meter_assert.svh"

  // count never passes its limit
  `RLM_ASSERT_IMPL(a_cnt_limit, clk_i, rst_ni, 1'b1, cnt_q <= CNT_MAX)
  // pending flag tracks a nonzero count
  `RLM_ASSERT_IMPL(a_pending_cnt, clk_i, rst_ni, 1'b1, pending_q == (cnt_q != '0))
  // divide never runs on an empty count
  `RLM_ASSERT_IMPL(a_div_nonzero, clk_i, rst_ni, state_q == ST_DIV, cnt_q != '0)
  // partial remainder stays below the divisor
  `RLM_ASSERT_IMPL(a_div_rem, clk_i, rst_ni, state_q == ST_DIV,
                   REM_W'(cnt_q) > rem_q)
  // a finished level is presented the next cycle
  `RLM_ASSERT_NEXT(a_done_out, clk_i, rst_ni, (state_q == ST_DONE) && out_free,
                   out_valid_q && (state_q == ST_IDLE))

endmodule

@@ dv/rms_level_meter_tb.sv @@
`timescale 1ns / 1ps

module rms_level_meter_tb;
  import rlm_pkg::*;

  localparam int METER_MAX      = MAX_COUNT_DEF;
  localparam int RANDOM_ITEMS   = 725;
  localparam int IDLE_MAX       = 12;
  // receiver hold-off to back the meter up into its input
  localparam int HOLD_AT_LEVEL  = 40;
  localparam int HOLD_CYCLES    = 400;
  // room for a tick's divide and root, plus the worst stalls on both sides
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic                        command;
    logic signed [SAMPLE_W-1:0]  value;
    int unsigned                 gap;
  } meter_item_t;

  logic clk_i;
  logic rst_ni;

  rlm_in_if  sample_bus ();
  rlm_out_if level_bus ();

  rms_level_meter #(
    .MAX_COUNT(METER_MAX)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_bus),
    .level_o (level_bus)
  );

  // items waiting for the driver, and levels waiting for the dut
  meter_item_t       pending_items[$];
  logic [LEVEL_W-1:0] expected_levels[$];

  // shadow of the meter state, advanced on every accepted input transfer
  logic [42:0] acc_sum;
  logic [12:0] acc_count;
  logic        acc_pending;

  int unsigned items_total;
  int unsigned items_accepted;
  int unsigned samples_taken;
  int unsigned samples_dropped;
  int unsigned ticks_taken;
  int unsigned idle_ticks;
  int unsigned levels_checked;
  int unsigned mismatches;
  int unsigned random_items;
  int unsigned idle_cycles;
  int unsigned stall_cycles_seen;

  // clock, 10 ns period
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // level prediction: integer mean of the squares and its floor root
  // ---------------------------------------------------------------------------
  task automatic meter_absorb(input logic cmd, input logic signed [SAMPLE_W-1:0] val);
    longint      square;
    logic [42:0] mean;
    logic [16:0] root;
    logic [16:0] trial;
    square = longint'(val) * longint'(val);
    if (cmd == CMD_SAMPLE) begin
      if (acc_count < METER_MAX) begin
        acc_sum     = acc_sum + square[42:0];
        acc_count   = acc_count + 1'b1;
        acc_pending = 1'b1;
        samples_taken++;
      end else begin
        // count full, sample dropped until the next tick
        samples_dropped++;
      end
    end else begin
      ticks_taken++;
      if (!acc_pending || acc_count == 0) begin
        // nothing to publish, state left alone
        idle_ticks++;
      end else begin
        mean = acc_sum / acc_count;
        root = '0;
        // build the root one bit at a time, keep a bit if its square still fits
        for (int b = 16; b >= 0; b--) begin
          trial = root | (17'd1 << b);
          if (longint'(trial) * longint'(trial) <= longint'(mean)) root = trial;
        end
        expected_levels.push_back(root[LEVEL_W-1:0]);
        acc_sum     = '0;
        acc_count   = '0;
        acc_pending = 1'b0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic cmd, input logic signed [SAMPLE_W-1:0] val,
                            input int unsigned gap);
    meter_item_t it;
    it.command = cmd;
    it.value   = val;
    it.gap     = gap;
    pending_items.push_back(it);
    items_total++;
  endtask

  // mix of extremes, values near zero and the full range
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: v = -16'sd32768;
          1: v = 16'sd32767;
          2: v = -16'sd1;
          3: v = 16'sd1;
          default: v = 16'sd0;
        endcase
      end
      1: begin
        v = 16'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        v = 16'($urandom);
      end
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: valid held until the transfer, then the next item after its gap
  // ---------------------------------------------------------------------------
  int unsigned gap_cnt;

  always @(posedge clk_i or negedge rst_ni) begin
    meter_item_t cur;
    if (!rst_ni) begin
      sample_bus.valid        <= 1'b0;
      sample_bus.command      <= CMD_SAMPLE;
      sample_bus.sample_value <= '0;
      gap_cnt                 <= 0;
    end else if (!(sample_bus.valid && !sample_bus.ready)) begin
      if (pending_items.size() != 0 && gap_cnt >= pending_items[0].gap) begin
        cur = pending_items.pop_front();
        sample_bus.valid        <= 1'b1;
        sample_bus.command      <= cur.command;
        sample_bus.sample_value <= cur.value;
        gap_cnt                 <= 0;
      end else begin
        sample_bus.valid <= 1'b0;
        if (pending_items.size() != 0) gap_cnt <= gap_cnt + 1;
      end
    end
  end

  // input monitor: every accepted transfer advances the prediction
  always @(posedge clk_i) begin
    if (rst_ni && sample_bus.valid && sample_bus.ready) begin
      meter_absorb(sample_bus.command, sample_bus.sample_value);
      items_accepted++;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random wait after each transfer, calm stretches, one long hold-off
  // ---------------------------------------------------------------------------
  int unsigned rx_taken;
  int unsigned rx_wait;
  int unsigned rx_hold;

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned n;
    if (!rst_ni) begin
      level_bus.ready <= 1'b0;
      rx_taken        <= 0;
      rx_wait         <= 0;
      rx_hold         <= 0;
    end else if (rx_hold != 0) begin
      level_bus.ready <= (rx_hold == 1);
      rx_hold         <= rx_hold - 1;
    end else if (level_bus.valid && level_bus.ready) begin
      rx_taken <= rx_taken + 1;
      // every third stretch of 32 levels runs without receiver stalls
      n = (((rx_taken / 32) % 3) == 2) ? 0 : $urandom_range(0, IDLE_MAX);
      if (rx_taken + 1 == HOLD_AT_LEVEL) begin
        level_bus.ready <= 1'b0;
        rx_hold         <= HOLD_CYCLES;
      end else if (n == 0) begin
        level_bus.ready <= 1'b1;
      end else begin
        level_bus.ready <= 1'b0;
        rx_wait         <= n;
      end
    end else if (rx_wait != 0) begin
      level_bus.ready <= (rx_wait == 1);
      rx_wait         <= rx_wait - 1;
    end else begin
      level_bus.ready <= 1'b1;
    end
  end

  // counts cycles of the receiver hold-off in which the sender offers but the meter is backed up
  always @(posedge clk_i) begin
    if (rst_ni && rx_hold != 0 && sample_bus.valid && !sample_bus.ready) begin
      stall_cycles_seen++;
    end
  end

  // output monitor: compare each level with the oldest prediction
  always @(posedge clk_i) begin
    logic [LEVEL_W-1:0] want;
    if (rst_ni && level_bus.valid && level_bus.ready) begin
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] unexpected level %0d, nothing predicted", $realtime,
                   level_bus.level);
        end
      end else begin
        want = expected_levels.pop_front();
        levels_checked++;
        if (level_bus.level !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] level mismatch: expected %0d, got %0d", $realtime, want,
                     level_bus.level);
          end
        end
      end
    end
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if ((sample_bus.valid && sample_bus.ready) || (level_bus.valid && level_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d levels outstanding",
                 WATCHDOG_LIMIT, expected_levels.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned gap_max;
    int unsigned k;
    rst_ni                  = 1'b0;
    sample_bus.valid        = 1'b0;
    sample_bus.command      = CMD_SAMPLE;
    sample_bus.sample_value = '0;
    level_bus.ready         = 1'b0;
    acc_sum                 = '0;
    acc_count               = '0;
    acc_pending             = 1'b0;
    items_total             = 0;
    items_accepted          = 0;
    samples_taken           = 0;
    samples_dropped         = 0;
    ticks_taken             = 0;
    idle_ticks              = 0;
    levels_checked          = 0;
    mismatches              = 0;
    random_items            = 0;
    idle_cycles             = 0;
    stall_cycles_seen       = 0;

    // directed: tick with nothing pending right after reset
    queue_item(CMD_TICK, 16'sd0, $urandom_range(0, 3));
    // silence, then each full-scale extreme on its own
    queue_item(CMD_SAMPLE, 16'sd0, 0);
    queue_item(CMD_TICK, 16'sd0, 0);
    queue_item(CMD_SAMPLE, 16'sd32767, $urandom_range(0, 3));
    queue_item(CMD_TICK, -16'sd1, 0);
    // most negative sample: root of 2^30 is 32768, the largest level the meter can produce
    queue_item(CMD_SAMPLE, -16'sd32768, 0);
    queue_item(CMD_TICK, 16'sd0, $urandom_range(0, 3));
    // second tick in a row has nothing to publish
    queue_item(CMD_TICK, 16'sd0, 0);
    queue_item(CMD_SAMPLE, -16'sd1, 0);
    queue_item(CMD_SAMPLE, 16'sd1, 0);
    queue_item(CMD_TICK, 16'sd0, 0);
    // mean of 12.5 floors to 12, root floors to 3
    queue_item(CMD_SAMPLE, 16'sd3, 0);
    queue_item(CMD_SAMPLE, -16'sd4, $urandom_range(0, 3));
    queue_item(CMD_TICK, 16'sd0, 0);
    // alternating bit patterns
    queue_item(CMD_SAMPLE, 16'sh5555, 0);
    queue_item(CMD_SAMPLE, 16'shAAAA, 0);
    queue_item(CMD_TICK, 16'sd0, 0);
    queue_item(CMD_SAMPLE, 16'sd32767, 0);
    queue_item(CMD_SAMPLE, -16'sd32768, 0);
    queue_item(CMD_SAMPLE, 16'sd0, 0);
    queue_item(CMD_TICK, 16'sd0, 0);
    queue_item(CMD_TICK, 16'sd0, 0);

    // random: mostly bursts of samples closed by a tick, some stray ticks
    while (random_items < RANDOM_ITEMS) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(1, 2);
        for (int i = 0; i < k; i++) begin
          queue_item(CMD_TICK, 16'($urandom), $urandom_range(0, gap_max));
        end
        random_items += k;
      end else begin
        k = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < k; i++) begin
          queue_item(CMD_SAMPLE, pick_sample(), $urandom_range(0, gap_max));
        end
        queue_item(CMD_TICK, 16'($urandom), $urandom_range(0, gap_max));
        random_items += k + 1;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // everything offered, every level back, then a quiet tail
    while (items_accepted != items_total) @(posedge clk_i);
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatches += expected_levels.size();

    $display("run covered %0d samples (%0d dropped at count full) and %0d ticks (%0d idle)",
             samples_taken, samples_dropped, ticks_taken, idle_ticks);
    $display("%0d levels checked, %0d cycles of input backpressure under receiver hold-off",
             levels_checked, stall_cycles_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
